### rtl/sgmd_pkg.sv
// shared types, constants and glyph rom for the scrolling glyph matrix display
`default_nettype none
package sgmd_pkg;
    localparam int WIDTH = 32;
    localparam int MAX_GLYPHS = 8;
    localparam int ROM_GLYPHS = 15;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [2:0] REG_HOLD    = 3'd0;
    localparam logic [2:0] REG_STEP    = 3'd1;
    localparam logic [2:0] REG_REPEATS = 3'd2;
    localparam logic [2:0] REG_ROTATE  = 3'd3;
    localparam logic [2:0] REG_FLIP    = 3'd4;
    localparam logic [2:0] REG_REVERSE = 3'd5;
    localparam logic [2:0] REG_SPACING = 3'd6;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_SCROLL = 2'd2
    } mode_t;

    function automatic logic [7:0] rom_byte(input logic [3:0] g, input logic [2:0] r);
        logic [63:0] row;
        begin
            case (g)
                4'd0:    row = 64'h7C407C10FE384438;
                4'd1:    row = 64'hF5858587_85F50505;
                4'd2:    row = 64'h7C447CFE1040407C;
                4'd3:    row = 64'h768A8E72007E0202;
                4'd4:    row = 64'h22222253528A0202;
                4'd5:    row = 64'h7C0414FE00384438;
                4'd6:    row = 64'h728A72FA2640407E;
                4'd7:    row = 64'h2222528A0040407E;
                4'd8:    row = 64'hFA8382FA003C423C;
                4'd9:    row = 64'h2223528A003C423C;
                4'd10:   row = 64'h728A7322FA3C423C;
                4'd11:   row = 64'h2222528A427E427E;
                4'd12:   row = 64'hFA0AFA8282FA0202;
                4'd13:   row = 64'h72FB52220040407E;
                4'd14:   row = 64'h738A8B72003C423C;
                default: row = 64'h0;
            endcase
            rom_byte = row[6'(63 - 8 * int'(r)) -: 8];
        end
    endfunction
endpackage
`default_nettype wire

### rtl/scrolling_glyph_matrix_display.sv
// top level of the scrolling glyph matrix display
// Drives an 8-row by 32-column LED matrix from a 15-glyph 8x8 rom. Each
// input transfer is one of: tick (advance time), load (stage a glyph; the
// last one commits the word) or clear. A word that fits is drawn centred and
// held static_hold_ticks ticks; a wider word scrolls one column per
// scroll_step_ticks ticks for scroll_repeats passes. Results are column
// writes (kind 1) or a single status result (kind 0); last marks the final
// result of an input. A single column sequencer produces one column per
// cycle while out_stall is low: an input that gives only a status result
// gives just that one result, an input that draws gives one result per
// column, up to 64 results for a frame followed by a clear. Input stall stays
// high while a run is in progress or while a result sits in the output
// register and out_stall holds it.
`default_nettype none
module scrolling_glyph_matrix_display (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  glyph_id,
    input  wire logic        last_glyph,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [4:0]       column,
    output logic [7:0]       pixels,
    output logic             last,
    output logic             active,
    output logic             rejected
);
    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FRAME  = 3'b010,
        ST_CLEAR  = 3'b100
    } state_t;

    // configuration
    logic [15:0] hold_reg, step_reg;
    logic [3:0]  repeats_reg;
    logic        rotate_reg, flip_reg, reverse_reg;
    logic [1:0]  spacing_reg;

    // display state
    sgmd_pkg::mode_t mode_reg;
    logic [3:0]  staged_reg [sgmd_pkg::MAX_GLYPHS];
    logic [3:0]  shown_reg  [sgmd_pkg::MAX_GLYPHS];
    logic [3:0]  staged_count_reg, shown_count_reg;
    logic        overflow_reg;
    logic [7:0]  width_reg;
    logic signed [9:0] pos_reg;
    logic [3:0]  passes_reg;
    logic [15:0] elapsed_reg;

    // sequencer
    state_t      state_reg;
    logic [4:0]  x_reg;          // logical column being produced
    logic        clear_after_reg; // a clear run follows this frame
    logic        static_reg;      // frame is centred static
    logic [7:0]  pad_reg;

    // output register
    logic        ov_reg;

    logic accept_in, out_free;
    assign out_free  = !ov_reg || !out_stall;
    assign accept_in = in_valid && !in_stall;
    // a result leaving this cycle frees the output register for the next input
    assign in_stall  = (state_reg != ST_IDLE) || (ov_reg && out_stall);

    // ---- configuration port ----
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_reg    <= 16'd3000;
            step_reg    <= 16'd80;
            repeats_reg <= 4'd1;
            rotate_reg  <= 1'b1;
            flip_reg    <= 1'b0;
            reverse_reg <= 1'b0;
            spacing_reg <= 2'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                sgmd_pkg::REG_HOLD:    hold_reg    <= cfg_data;
                sgmd_pkg::REG_STEP:    step_reg    <= cfg_data;
                sgmd_pkg::REG_REPEATS: repeats_reg <= cfg_data[3:0];
                sgmd_pkg::REG_ROTATE:  rotate_reg  <= cfg_data[0];
                sgmd_pkg::REG_FLIP:    flip_reg    <= cfg_data[0];
                sgmd_pkg::REG_REVERSE: reverse_reg <= cfg_data[0];
                sgmd_pkg::REG_SPACING: spacing_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---- column source: one text column per cycle while the output is free ----
    logic signed [10:0] src;
    logic        in_text;
    logic [7:0]  tx;
    logic [2:0]  gidx;
    logic [5:0]  gcol;
    logic [7:0]  col_raw, col_out;
    logic [7:0]  rb;
    logic [3:0]  gsel;

    always_comb begin
        if (static_reg)
            src = 11'($signed({3'b000, x_reg})) - 11'($signed({3'b000, pad_reg}));
        else
            src = 11'(pos_reg) + 11'($signed({6'b0, x_reg}));
        in_text = (src >= 0) && (src < $signed({3'b000, width_reg}));
        tx = src[7:0];
        // stride is 8, 16, 24 or 32: split by cases on the spacing
        case (spacing_reg)
            2'd0: begin gidx = tx[5:3]; gcol = {3'b0, tx[2:0]}; end
            2'd1: begin gidx = tx[6:4]; gcol = {2'b0, tx[3:0]}; end
            2'd2: begin
                // divide by 24 through a reciprocal multiply
                gidx = 3'(({8'd0, tx} * 16'd171) >> 12);
                gcol = 6'(tx - 8'(gidx) * 8'd24);
            end
            default: begin gidx = tx[7:5]; gcol = {1'b0, tx[4:0]}; end
        endcase
        gsel = shown_reg[gidx];
        col_raw = 8'd0;
        rb = 8'd0;
        if (rotate_reg)
            col_raw = sgmd_pkg::rom_byte(gsel, gcol[2:0]);
        else
            for (int r = 0; r < 8; r++) begin
                rb = sgmd_pkg::rom_byte(gsel, 3'(r));
                col_raw[r] = rb[3'd7 - gcol[2:0]];
            end
        if (!in_text || ({1'b0, gidx} >= shown_count_reg) || gcol >= 6'd8
            || gsel == 4'd15)
            col_raw = 8'd0;
        col_out = col_raw;
        if (flip_reg)
            for (int r = 0; r < 8; r++)
                col_out[r] = col_raw[7 - r];
    end

    // ---- commit and tick arithmetic ----
    logic [3:0]  cnt;
    logic [3:0]  cnt1;
    logic [7:0]  w_load;
    logic [15:0] el_inc;
    assign cnt    = staged_count_reg;
    assign cnt1   = cnt + 4'd1;
    // width of the word being committed, including the glyph in this transfer
    assign w_load = 8'({cnt1, 3'b000} + 7'(cnt) * {spacing_reg, 3'b000});
    assign el_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    logic [3:0] target;
    assign target = (repeats_reg == 4'd0) ? 4'd1 : repeats_reg;

    logic signed [9:0] pos_inc;
    logic [3:0] passes_inc;
    logic       pass_end;
    assign pos_inc    = pos_reg + 10'sd1;
    assign passes_inc = passes_reg + 4'd1;
    assign pass_end   = (pos_inc >= $signed({2'b00, width_reg}));

    // decode of the input transfer
    logic tick_clear, tick_frame, commit_bad, run_starts;
    assign tick_clear = (mode_reg == sgmd_pkg::MODE_STATIC) && (el_inc >= hold_reg);
    assign tick_frame = (mode_reg == sgmd_pkg::MODE_SCROLL) && (el_inc >= step_reg);
    assign commit_bad = overflow_reg || (staged_count_reg >= 4'(sgmd_pkg::MAX_GLYPHS));

    always_comb begin
        case (func)
            sgmd_pkg::FUNC_TICK:  run_starts = tick_clear || tick_frame;
            sgmd_pkg::FUNC_LOAD:  run_starts = last_glyph && !commit_bad;
            sgmd_pkg::FUNC_CLEAR: run_starts = 1'b1;
            default:              run_starts = 1'b0;
        endcase
    end

    // output payload registers
    logic kind_reg, last_reg, active_reg, rej_reg;
    logic [4:0] column_reg;
    logic [7:0] pixels_reg;
    logic       is_last_col;
    assign is_last_col = (x_reg == 5'(sgmd_pkg::WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            mode_reg         <= sgmd_pkg::MODE_IDLE;
            staged_count_reg <= 4'd0;
            shown_count_reg  <= 4'd0;
            overflow_reg     <= 1'b0;
            width_reg        <= 8'd0;
            pos_reg          <= 10'sd0;
            passes_reg       <= 4'd0;
            elapsed_reg      <= 16'd0;
            ov_reg           <= 1'b0;
            x_reg            <= 5'd0;
            clear_after_reg  <= 1'b0;
            static_reg       <= 1'b0;
            pad_reg          <= 8'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        // status result unless a run starts
                        ov_reg     <= !run_starts;
                        kind_reg   <= 1'b0;
                        column_reg <= 5'd0;
                        pixels_reg <= 8'd0;
                        last_reg   <= 1'b1;
                        rej_reg    <= (func == sgmd_pkg::FUNC_LOAD) && last_glyph
                                      && commit_bad;
                        active_reg <= (mode_reg != sgmd_pkg::MODE_IDLE);
                        x_reg      <= 5'd0;
                        case (func)
                            sgmd_pkg::FUNC_TICK: begin
                                if (tick_frame)
                                    elapsed_reg <= 16'd0;
                                else
                                    elapsed_reg <= el_inc;
                                if (tick_clear) begin
                                    state_reg <= ST_CLEAR;
                                    mode_reg  <= sgmd_pkg::MODE_IDLE;
                                    width_reg <= 8'd0;
                                end else if (tick_frame) begin
                                    pos_reg         <= pos_inc;
                                    static_reg      <= 1'b0;
                                    state_reg       <= ST_FRAME;
                                    clear_after_reg <= pass_end && (passes_inc >= target);
                                    if (pass_end)
                                        passes_reg <= passes_inc;
                                    if (pass_end && passes_inc >= target)
                                        mode_reg <= sgmd_pkg::MODE_IDLE;
                                end
                            end
                            sgmd_pkg::FUNC_LOAD: begin
                                if (last_glyph) begin
                                    // staging empties on every commit
                                    staged_count_reg <= 4'd0;
                                    overflow_reg     <= 1'b0;
                                    if (!commit_bad) begin
                                        state_reg       <= ST_FRAME;
                                        clear_after_reg <= 1'b0;
                                        elapsed_reg     <= 16'd0;
                                        for (int i = 0; i < sgmd_pkg::MAX_GLYPHS; i++)
                                            shown_reg[i] <= (3'(i) == staged_count_reg[2:0])
                                                            ? glyph_id : staged_reg[i];
                                        shown_count_reg <= cnt1;
                                        width_reg <= w_load;
                                        if (w_load <= 8'(sgmd_pkg::WIDTH)) begin
                                            mode_reg   <= sgmd_pkg::MODE_STATIC;
                                            static_reg <= 1'b1;
                                            pad_reg    <= (8'(sgmd_pkg::WIDTH) - w_load) >> 1;
                                        end else begin
                                            mode_reg   <= sgmd_pkg::MODE_SCROLL;
                                            static_reg <= 1'b0;
                                            pos_reg    <= -10'(sgmd_pkg::WIDTH);
                                            passes_reg <= 4'd0;
                                        end
                                    end
                                end else if (staged_count_reg < 4'(sgmd_pkg::MAX_GLYPHS)) begin
                                    staged_reg[staged_count_reg[2:0]] <= glyph_id;
                                    staged_count_reg <= staged_count_reg + 4'd1;
                                end else begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            sgmd_pkg::FUNC_CLEAR: begin
                                state_reg <= ST_CLEAR;
                                mode_reg  <= sgmd_pkg::MODE_IDLE;
                                width_reg <= 8'd0;
                            end
                            default: ;
                        endcase
                    end else if (ov_reg && !out_stall) begin
                        ov_reg <= 1'b0;
                    end
                end
                ST_FRAME: begin
                    if (out_free) begin
                        ov_reg     <= 1'b1;
                        kind_reg   <= 1'b1;
                        column_reg <= reverse_reg ? 5'(sgmd_pkg::WIDTH - 1) - x_reg : x_reg;
                        pixels_reg <= col_out;
                        rej_reg    <= 1'b0;
                        active_reg <= (mode_reg != sgmd_pkg::MODE_IDLE);
                        last_reg   <= is_last_col && !clear_after_reg;
                        x_reg      <= x_reg + 5'd1;
                        if (is_last_col) begin
                            if (clear_after_reg) begin
                                state_reg <= ST_CLEAR;
                                width_reg <= 8'd0;
                            end else begin
                                state_reg <= ST_IDLE;
                                if (mode_reg == sgmd_pkg::MODE_SCROLL
                                    && pos_reg >= $signed({2'b00, width_reg}))
                                    pos_reg <= -10'(sgmd_pkg::WIDTH);
                            end
                        end
                    end
                end
                ST_CLEAR: begin
                    if (out_free) begin
                        ov_reg     <= 1'b1;
                        kind_reg   <= 1'b1;
                        column_reg <= x_reg;
                        pixels_reg <= 8'd0;
                        rej_reg    <= 1'b0;
                        active_reg <= 1'b0;
                        last_reg   <= is_last_col;
                        x_reg      <= x_reg + 5'd1;
                        if (is_last_col) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign column    = column_reg;
    assign pixels    = pixels_reg;
    assign last      = last_reg;
    assign active    = active_reg;
    assign rejected  = rej_reg;

`ifndef NO_ASSERTIONS
    // a rejected commit is a single status result
    a_rej_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (!kind && last))
        else $error("rejected result not a lone status");
    // no input is taken while a run is in progress
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept_in)
        else $error("input accepted during a run");
    // clear run writes blank columns with inactive status
    a_clear_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && out_free) |=> (pixels == 8'd0 && !active))
        else $error("clear run wrote pixels");
    // static mode only holds words that fit the matrix
    a_static_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sgmd_pkg::MODE_STATIC) |-> (width_reg <= 8'(sgmd_pkg::WIDTH)))
        else $error("static word wider than matrix");
`endif
endmodule
`default_nettype wire

### sim/testbench.sv
// self-checking testbench for the scrolling glyph matrix display
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [3:0]  glyph_id;
    logic        last_glyph;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [4:0]  column;
    logic [7:0]  pixels;
    logic        last;
    logic        active;
    logic        rejected;

    // func value the block treats as a no-op (status result only)
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam logic [3:0] BLANK_GLYPH = 4'd15;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_ITEMS = 30;

    scrolling_glyph_matrix_display u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .glyph_id  (glyph_id),
        .last_glyph(last_glyph),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .column    (column),
        .pixels    (pixels),
        .last      (last),
        .active    (active),
        .rejected  (rejected)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // expected column writes and status results, oldest first
    // ------------------------------------------------------------------
    typedef struct packed {
        logic       kind;
        logic [4:0] column;
        logic [7:0] pixels;
        logic       last;
        logic       active;
        logic       rejected;
    } display_write_t;

    display_write_t expected_writes[$];
    display_write_t frame_buf[$];

    int errors;
    int items_sent;
    int writes_checked;
    int frames_seen;
    int rejects_seen;
    bit calm;              // no idling on either side while set
    int hold_requests;     // bumped by a test to ask for a long receiver hold
    int holds_served;
    int hold_left;
    int quiet_cycles;

    // own copy of the 8x8 font, row 0 in the top byte
    localparam logic [63:0] FONT [sgmd_pkg::ROM_GLYPHS] = '{
        64'h7C407C10FE384438, 64'hF585858785F50505, 64'h7C447CFE1040407C,
        64'h768A8E72007E0202, 64'h22222253528A0202, 64'h7C0414FE00384438,
        64'h728A72FA2640407E, 64'h2222528A0040407E, 64'hFA8382FA003C423C,
        64'h2223528A003C423C, 64'h728A7322FA3C423C, 64'h2222528A427E427E,
        64'hFA0AFA8282FA0202, 64'h72FB52220040407E, 64'h738A8B72003C423C
    };

    // ------------------------------------------------------------------
    // display predictor state
    // ------------------------------------------------------------------
    logic [15:0] hold_ticks_cfg;
    logic [15:0] step_ticks_cfg;
    logic [3:0]  repeats_cfg;
    logic        rotate_cfg;
    logic        flip_cfg;
    logic        reverse_cfg;
    logic [1:0]  spacing_cfg;

    sgmd_pkg::mode_t disp_mode;
    logic [3:0]  staged_ids [sgmd_pkg::MAX_GLYPHS];
    int          staged_cnt;
    bit          staged_ovf;
    logic [3:0]  shown_ids [sgmd_pkg::MAX_GLYPHS];
    int          shown_cnt;
    int          word_cols;
    int          scroll_pos;
    int          passes;
    int          elapsed;

    // column byte of glyph g at glyph column x after rotate and flip
    function automatic logic [7:0] glyph_column(input int g, input int x);
        logic [7:0] col;
        logic [7:0] flipped;
        col = '0;
        if (g >= sgmd_pkg::ROM_GLYPHS || x >= 8)
            return '0;
        if (rotate_cfg)
            col = FONT[g][8*(7-x) +: 8];
        else
            for (int r = 0; r < 8; r++)
                col[r] = FONT[g][8*(7-r) + (7-x)];
        if (flip_cfg)
        begin
            for (int r = 0; r < 8; r++)
                flipped[7-r] = col[r];
            col = flipped;
        end
        return col;
    endfunction

    // column x of the shown word, spacing cells blank
    function automatic logic [7:0] word_column(input int x);
        int stride;
        int idx;
        int offs;
        stride = 8 + 8 * int'(spacing_cfg);
        idx = x / stride;
        offs = x % stride;
        if (idx >= shown_cnt || offs >= 8)
            return '0;
        return glyph_column(int'(shown_ids[idx]), offs);
    endfunction

    function automatic void emit(input logic k, input int col, input logic [7:0] pix,
                                 input logic rej);
        display_write_t w;
        w = '0;
        w.kind = k;
        w.column = col[4:0];
        w.pixels = pix;
        w.rejected = rej;
        frame_buf.push_back(w);
    endfunction

    function automatic void emit_logical(input int lc, input logic [7:0] pix);
        emit(1'b1, reverse_cfg ? sgmd_pkg::WIDTH - 1 - lc : lc, pix, 1'b0);
    endfunction

    function automatic void draw_centred();
        int pad;
        pad = word_cols < sgmd_pkg::WIDTH ? (sgmd_pkg::WIDTH - word_cols) / 2 : 0;
        frames_seen++;
        for (int x = 0; x < sgmd_pkg::WIDTH; x++)
            emit_logical(x, (x >= pad && x < pad + word_cols) ? word_column(x - pad) : 8'h00);
    endfunction

    function automatic void draw_scrolled();
        int src;
        frames_seen++;
        for (int x = 0; x < sgmd_pkg::WIDTH; x++)
        begin
            src = scroll_pos + x;
            emit_logical(x, (src >= 0 && src < word_cols) ? word_column(src) : 8'h00);
        end
    endfunction

    function automatic void blank_display();
        for (int x = 0; x < sgmd_pkg::WIDTH; x++)
            emit(1'b1, x, 8'h00, 1'b0);
        word_cols = 0;
        disp_mode = sgmd_pkg::MODE_IDLE;
    endfunction

    function automatic void advance_time();
        int target;
        if (elapsed < 65535)
            elapsed++;
        if (disp_mode == sgmd_pkg::MODE_STATIC)
        begin
            if (elapsed >= int'(hold_ticks_cfg))
                blank_display();
            return;
        end
        if (disp_mode != sgmd_pkg::MODE_SCROLL || elapsed < int'(step_ticks_cfg))
            return;
        elapsed = 0;
        scroll_pos++;
        draw_scrolled();
        if (scroll_pos >= word_cols)
        begin
            passes = (passes + 1) & 15;
            target = repeats_cfg == 0 ? 1 : int'(repeats_cfg);
            if (passes >= target)
                blank_display();
            else
                scroll_pos = -sgmd_pkg::WIDTH;
        end
    endfunction

    function automatic void stage_glyph(input logic [3:0] g, input logic commit);
        if (staged_cnt < sgmd_pkg::MAX_GLYPHS)
        begin
            staged_ids[staged_cnt] = g;
            staged_cnt++;
        end
        else
            staged_ovf = 1'b1;
        if (!commit)
            return;
        if (staged_ovf || staged_cnt == 0)
        begin
            staged_cnt = 0;
            staged_ovf = 1'b0;
            rejects_seen++;
            emit(1'b0, 0, 8'h00, 1'b1);
            return;
        end
        for (int i = 0; i < staged_cnt; i++)
            shown_ids[i] = staged_ids[i];
        shown_cnt = staged_cnt;
        staged_cnt = 0;
        staged_ovf = 1'b0;
        word_cols = (shown_cnt * 8 + (shown_cnt - 1) * int'(spacing_cfg) * 8) & 255;
        elapsed = 0;
        if (word_cols <= sgmd_pkg::WIDTH)
        begin
            disp_mode = sgmd_pkg::MODE_STATIC;
            draw_centred();
        end
        else
        begin
            scroll_pos = -sgmd_pkg::WIDTH;
            passes = 0;
            disp_mode = sgmd_pkg::MODE_SCROLL;
            draw_scrolled();
        end
    endfunction

    // works out every write caused by one accepted input transfer
    function automatic void predict_display(input logic [1:0] f, input logic [3:0] g,
                                            input logic l);
        display_write_t w;
        frame_buf.delete();
        case (f)
            sgmd_pkg::FUNC_TICK:  advance_time();
            sgmd_pkg::FUNC_LOAD:  stage_glyph(g, l);
            sgmd_pkg::FUNC_CLEAR: blank_display();
            default:              ;
        endcase
        if (frame_buf.size() == 0)
            emit(1'b0, 0, 8'h00, 1'b0);
        foreach (frame_buf[k])
        begin
            w = frame_buf[k];
            w.last = (k == frame_buf.size() - 1);
            w.active = (disp_mode != sgmd_pkg::MODE_IDLE);
            expected_writes.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report(input string what, input int got, input int want);
        if (errors < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        display_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_writes.size() == 0)
                report("unexpected transfer, column", column, -1);
            else
            begin
                want = expected_writes.pop_front();
                writes_checked++;
                if (kind !== want.kind)         report("kind", kind, want.kind);
                if (column !== want.column)     report("column", column, want.column);
                if (pixels !== want.pixels)     report("pixels", pixels, want.pixels);
                if (last !== want.last)         report("last", last, want.last);
                if (active !== want.active)     report("active", active, want.active);
                if (rejected !== want.rejected) report("rejected", rejected, want.rejected);
            end
        end
    end

    // receiver: random stalls, or a long hold when a test asks for one
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d writes outstanding", expected_writes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] f, input logic [3:0] g, input logic l);
        int gap;
        if (!calm && $urandom_range(99) < 31)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        glyph_id <= g;
        last_glyph <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_display(f, g, l);
        items_sent++;
    endtask

    // sender pauses until every expected write has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            sgmd_pkg::REG_HOLD:    hold_ticks_cfg = val;
            sgmd_pkg::REG_STEP:    step_ticks_cfg = val;
            sgmd_pkg::REG_REPEATS: repeats_cfg = val[3:0];
            sgmd_pkg::REG_ROTATE:  rotate_cfg = val[0];
            sgmd_pkg::REG_FLIP:    flip_cfg = val[0];
            sgmd_pkg::REG_REVERSE: reverse_cfg = val[0];
            sgmd_pkg::REG_SPACING: spacing_cfg = val[1:0];
            default:               ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] hold, input logic [15:0] step,
                              input logic [3:0] reps, input logic rot, input logic flip,
                              input logic rev, input logic [1:0] sp);
        wait_drained();
        write_reg(sgmd_pkg::REG_HOLD, hold);
        write_reg(sgmd_pkg::REG_STEP, step);
        write_reg(sgmd_pkg::REG_REPEATS, 16'(reps));
        write_reg(sgmd_pkg::REG_ROTATE, 16'(rot));
        write_reg(sgmd_pkg::REG_FLIP, 16'(flip));
        write_reg(sgmd_pkg::REG_REVERSE, 16'(rev));
        write_reg(sgmd_pkg::REG_SPACING, 16'(sp));
    endtask

    // a word of n glyphs; first_id < 0 picks random ids, else consecutive ids
    task automatic send_word(input int n, input int first_id);
        for (int i = 0; i < n; i++)
            send_item(sgmd_pkg::FUNC_LOAD,
                      first_id < 0 ? 4'($urandom_range(15)) : 4'(first_id + i),
                      i == n - 1);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(sgmd_pkg::FUNC_TICK, 4'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_status_items();
        // ticks while idle, the unused func code, then a clear of a blank display
        send_item(sgmd_pkg::FUNC_TICK, 4'hF, 1'b1);
        send_item(FUNC_NOP, 4'h0, 1'b0);
        send_item(FUNC_NOP, 4'hF, 1'b1);
        send_item(sgmd_pkg::FUNC_CLEAR, 4'h5, 1'b1);
    endtask

    task automatic test_glyph_rom();
        // each glyph id under one of the orientations; four glyphs fill the width exactly
        set_config(16'd3000, 16'd80, 4'd1, 1'b1, 1'b0, 1'b0, 2'd0);
        send_word(4, 0);
        set_config(16'hFFFF, 16'hFFFF, 4'd1, 1'b0, 1'b1, 1'b1, 2'd0);
        send_word(4, 4);
        set_config(16'hFFFF, 16'd80, 4'd1, 1'b0, 1'b0, 1'b0, 2'd0);
        send_word(4, 8);
        set_config(16'hFFFF, 16'd80, 4'd1, 1'b1, 1'b1, 1'b0, 2'd1);
        send_word(2, 12);
        send_word(2, 14);     // commit while showing; id 15 is blank
        send_item(sgmd_pkg::FUNC_LOAD, BLANK_GLYPH, 1'b1);
    endtask

    task automatic test_word_limits();
        // nine glyphs overflow and are rejected; eight glyphs then scroll
        send_word(9, -1);
        set_config(16'd3000, 16'd80, 4'd1, 1'b1, 1'b0, 1'b0, 2'd3);
        send_word(8, 0);
        send_item(sgmd_pkg::FUNC_CLEAR, 4'd0, 1'b0);
    endtask

    task automatic test_static_timeout();
        set_config(16'd3, 16'd80, 4'd1, 1'b1, 1'b0, 1'b1, 2'd0);
        send_word(2, -1);
        send_ticks(4);
        set_config(16'd0, 16'd80, 4'd1, 1'b1, 1'b0, 1'b0, 2'd0);
        send_word(1, -1);
        send_ticks(2);
    endtask

    task automatic test_scroll_passes();
        // five glyphs: 40 columns; first pass wraps, then a zero repeat count ends it
        set_config(16'd3000, 16'd0, 4'd2, 1'b1, 1'b0, 1'b0, 2'd0);
        send_word(5, -1);
        send_ticks(40 + sgmd_pkg::WIDTH);
        set_config(16'd3000, 16'd0, 4'd0, 1'b0, 1'b1, 1'b1, 2'd0);
        send_ticks(40 + sgmd_pkg::WIDTH + 1);
        // largest repeat count, interrupted by a new word and by a clear
        set_config(16'd3000, 16'd1, 4'd15, 1'b0, 1'b1, 1'b1, 2'd0);
        send_word(5, -1);
        send_ticks(4);
        send_word(6, -1);
        send_ticks(2);
        send_item(sgmd_pkg::FUNC_CLEAR, 4'd0, 1'b1);
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering, so input stalls
        set_config(16'd20, 16'd2, 4'd3, 1'b1, 1'b0, 1'b0, 2'd0);
        calm = 1'b1;
        hold_requests++;
        send_word(6, -1);
        send_ticks(6);
        calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int start;
        int phase_start;
        int pick;
        int len;
        start = items_sent;
        phase_start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - phase_start > 10)
            begin
                phase_start = items_sent;
                set_config(
                    $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 12)),
                    $urandom_range(5) == 0 ? 16'hFFFF : 16'($urandom_range(0, 3)),
                    4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
            end
            // one long stretch with no idling on either side
            calm = (items_sent - start > 8 && items_sent - start < 22);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = $urandom_range(9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8);
                send_word(len, -1);
                send_ticks($urandom_range(0, 12));
            end
            else if (pick < 65)
                send_item(sgmd_pkg::FUNC_CLEAR, 4'($urandom), 1'($urandom));
            else if (pick < 73)
                send_item(FUNC_NOP, 4'($urandom), 1'($urandom));
            else if (pick < 80)
                send_item(sgmd_pkg::FUNC_LOAD, 4'($urandom), 1'b0);
            else
                send_ticks($urandom_range(1, 20));
        end
        calm = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = sgmd_pkg::FUNC_TICK;
        glyph_id = '0;
        last_glyph = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        items_sent = 0;
        writes_checked = 0;
        frames_seen = 0;
        rejects_seen = 0;
        calm = 1'b0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        // predictor matches the block's reset state
        hold_ticks_cfg = 16'd3000;
        step_ticks_cfg = 16'd80;
        repeats_cfg = 4'd1;
        rotate_cfg = 1'b1;
        flip_cfg = 1'b0;
        reverse_cfg = 1'b0;
        spacing_cfg = 2'd0;
        disp_mode = sgmd_pkg::MODE_IDLE;
        staged_cnt = 0;
        staged_ovf = 1'b0;
        shown_cnt = 0;
        word_cols = 0;
        scroll_pos = 0;
        passes = 0;
        elapsed = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_items();
        test_glyph_rom();
        test_word_limits();
        test_static_timeout();
        test_scroll_passes();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (80) @(posedge clk);
        $display("covered %0d input transfers, %0d result transfers checked", items_sent,
                 writes_checked);
        $display("drew %0d frames, rejected %0d words", frames_seen, rejects_seen);
        if (errors == 0 && expected_writes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/sgmd_pkg.sv
rtl/scrolling_glyph_matrix_display.sv
sim/testbench.sv
